@@ hw/rtl/pdps_pkg.sv @@
// Shared types, widths and constants of the PWM duty and phase sweep unit.
package pdps_pkg;

  // Width of the PWM counter values (duty, phase, compare outputs internally).
  localparam int COUNT_W = 16;
  // Number of fraction bits of the unsigned bound fractions.
  localparam int FRACTION_BITS = 16;
  // Width of every configuration register.
  localparam int CFG_W = 16;
  // Width of the compare fields at the ports.
  localparam int OUT_W = 16;
  // Common width that holds both a counter value and a register value.
  localparam int BASE_W = (COUNT_W > CFG_W) ? COUNT_W : ((OUT_W > CFG_W) ? OUT_W : CFG_W);
  // Width of a fraction times a base.
  localparam int PROD_W = CFG_W + BASE_W;
  // Width of the configuration register index.
  localparam int CFG_IDX_W = 3;

  // Duty after reset.
  localparam int START_DUTY = 4000;

  // Register values after reset.
  localparam logic [CFG_W-1:0] RST_DUTY_STEP      = CFG_W'(0);
  localparam logic [CFG_W-1:0] RST_PHASE_STEP     = CFG_W'(100);
  localparam logic [CFG_W-1:0] RST_PERIOD_COUNT   = CFG_W'(9999);
  localparam logic [CFG_W-1:0] RST_DUTY_UPPER     = CFG_W'(52429);
  localparam logic [CFG_W-1:0] RST_DUTY_LOWER     = CFG_W'(13107);
  localparam logic [CFG_W-1:0] RST_PHASE_UPPER    = CFG_W'(26214);
  localparam logic [CFG_W-1:0] RST_PHASE_LOWER    = CFG_W'(6554);
  localparam logic [CFG_W-1:0] RST_HELD_DUTY      = CFG_W'(4000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DUTY_STEP,
    REG_PHASE_STEP,
    REG_PERIOD_COUNT,
    REG_DUTY_UPPER_FRACTION,
    REG_DUTY_LOWER_FRACTION,
    REG_PHASE_UPPER_FRACTION,
    REG_PHASE_LOWER_FRACTION,
    REG_HELD_DUTY
  } cfg_reg_e;

  typedef struct packed {
    logic [CFG_W-1:0] duty_step;
    logic [CFG_W-1:0] phase_step;
    logic [CFG_W-1:0] period_count;
    logic [CFG_W-1:0] duty_upper_fraction;
    logic [CFG_W-1:0] duty_lower_fraction;
    logic [CFG_W-1:0] phase_upper_fraction;
    logic [CFG_W-1:0] phase_lower_fraction;
    logic [CFG_W-1:0] held_duty;
  } cfg_t;

  // Sweep bounds, all already scaled to counter values.
  typedef struct packed {
    logic [COUNT_W-1:0] duty_lo;
    logic [COUNT_W-1:0] duty_hi;
    logic [COUNT_W-1:0] phase_lo;
    logic [COUNT_W-1:0] phase_hi;
    logic [COUNT_W-1:0] restart_phase;
  } bounds_t;

  function automatic logic [BASE_W-1:0] cfg_to_base(logic [CFG_W-1:0] v);
    return BASE_W'(v);
  endfunction

  function automatic logic [BASE_W-1:0] count_to_base(logic [COUNT_W-1:0] v);
    return BASE_W'(v);
  endfunction

  // A register value masked to the counter width.
  function automatic logic [COUNT_W-1:0] cfg_to_count(logic [CFG_W-1:0] v);
    logic [BASE_W-1:0] wide;
    wide = BASE_W'(v);
    return wide[COUNT_W-1:0];
  endfunction

endpackage

@@ hw/rtl/pdps_bounds.sv @@
// Registered bound products. Each bound is a fraction times a base, shifted
// down by the fraction bits and masked to the counter width.
module pdps_bounds (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pdps_pkg::cfg_t              cfg_i,
  input  logic [pdps_pkg::COUNT_W-1:0] duty_i,
  input  logic                        use_held_i,
  output pdps_pkg::bounds_t           bounds_o
);

  function automatic logic [pdps_pkg::COUNT_W-1:0] scale(
    logic [pdps_pkg::CFG_W-1:0]  frac,
    logic [pdps_pkg::BASE_W-1:0] base
  );
    logic [pdps_pkg::PROD_W-1:0] prod;
    logic [pdps_pkg::PROD_W-1:0] shifted;
    prod    = pdps_pkg::PROD_W'(frac) * pdps_pkg::PROD_W'(base);
    shifted = prod >> pdps_pkg::FRACTION_BITS;
    return shifted[pdps_pkg::COUNT_W-1:0];
  endfunction

  logic [pdps_pkg::COUNT_W-1:0] held_count;
  logic [pdps_pkg::BASE_W-1:0]  phase_base;
  pdps_pkg::bounds_t            bounds_d, bounds_q;

  assign held_count = pdps_pkg::cfg_to_count(cfg_i.held_duty);

  // While a restart in phase mode is under way the duty is about to become
  // the held duty, so the phase bounds follow it right away.
  assign phase_base = use_held_i ? pdps_pkg::count_to_base(held_count)
                                 : pdps_pkg::count_to_base(duty_i);

  always_comb begin
    bounds_d.duty_lo = scale(cfg_i.duty_lower_fraction,
                             pdps_pkg::cfg_to_base(cfg_i.period_count));
    bounds_d.duty_hi = scale(cfg_i.duty_upper_fraction,
                             pdps_pkg::cfg_to_base(cfg_i.period_count));
    bounds_d.phase_lo = scale(cfg_i.phase_lower_fraction, phase_base);
    bounds_d.phase_hi = scale(cfg_i.phase_upper_fraction, phase_base);
    bounds_d.restart_phase = scale(cfg_i.phase_lower_fraction,
                                   pdps_pkg::count_to_base(held_count));
  end

  // The products are refreshed in every cycle. No tick can use them before
  // the first edge after reset has loaded them.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bounds_q <= '0;
    end else begin
      bounds_q <= bounds_d;
    end
  end

  assign bounds_o = bounds_q;

endmodule

@@ hw/rtl/pwm_duty_phase_sweep_unit.sv @@
// PWM duty and phase sweep unit. Every input beat is one timer tick: with
// restart_i low it moves a triangle sweep one step, with restart_i high it
// reloads the start values, and in both cases it returns one result beat with
// the three PWM compare values and the sweep direction. When phase_step is
// zero the duty ramps between two fractions of period_count; otherwise the
// duty stays put and the phase ramps between two fractions of the duty. The
// lead compare is duty plus twice the phase (saturated at full scale) and the
// lag compare is duty minus twice the phase (saturated at zero). The unit
// takes one beat per clock cycle unless the result channel stalls or a
// configuration write is settling. A beat is taken into the input register
// and moves on into the result register once the result register is empty
// or being emptied and no configuration write is settling. The bounds are
// products of a fraction and a base held in their own registers; after a
// configuration write the unit therefore holds back the next tick, so that
// every bound reflects the new register values. The configuration port is always ready.
module pwm_duty_phase_sweep_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  // Configuration write channel.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pdps_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [pdps_pkg::CFG_W-1:0]     cfg_data_i,

  // Tick channel.
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           restart_i,

  // Result channel.
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [pdps_pkg::OUT_W-1:0]     center_compare_o,
  output logic [pdps_pkg::OUT_W-1:0]     lead_compare_o,
  output logic [pdps_pkg::OUT_W-1:0]     lag_compare_o,
  output logic                           sweeping_down_o
);

  localparam int CW = pdps_pkg::COUNT_W;
  localparam int BW = pdps_pkg::BASE_W;

  // Configuration registers.
  pdps_pkg::cfg_t cfg_q;
  logic           cfg_fire;
  logic           settle_q;

  // Input register.
  logic s1_valid_q;
  logic s1_restart_q;
  logic advance;

  // Sweep state.
  logic [CW-1:0] duty_q, duty_d;
  logic [CW-1:0] phase_q, phase_d;
  logic          falling_q, falling_d;

  // Result register.
  logic                       out_valid_q;
  logic [pdps_pkg::OUT_W-1:0] center_q, lead_q, lag_q;
  logic                       down_q;

  pdps_pkg::bounds_t bounds;
  logic              phase_mode;
  logic              use_held;

  // Sweep step of the selected value.
  logic [CW-1:0] sw_val, sw_lo, sw_hi, sw_next;
  logic [pdps_pkg::CFG_W-1:0] sw_step;
  logic [BW:0]   rise_sum, fall_limit;
  logic [BW-1:0] fall_diff;
  logic          rise_hit, fall_hit;

  // Compare values.
  logic [CW:0]     twice;
  logic [CW+1:0]   lead_sum;
  logic [CW:0]     lag_diff;
  logic [CW-1:0]   lead_val, lag_val;
  logic [BW-1:0]   center_w, lead_w, lag_w;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.duty_step            <= pdps_pkg::RST_DUTY_STEP;
      cfg_q.phase_step           <= pdps_pkg::RST_PHASE_STEP;
      cfg_q.period_count         <= pdps_pkg::RST_PERIOD_COUNT;
      cfg_q.duty_upper_fraction  <= pdps_pkg::RST_DUTY_UPPER;
      cfg_q.duty_lower_fraction  <= pdps_pkg::RST_DUTY_LOWER;
      cfg_q.phase_upper_fraction <= pdps_pkg::RST_PHASE_UPPER;
      cfg_q.phase_lower_fraction <= pdps_pkg::RST_PHASE_LOWER;
      cfg_q.held_duty            <= pdps_pkg::RST_HELD_DUTY;
      settle_q                   <= 1'b0;
    end else begin
      settle_q <= cfg_fire;
      if (cfg_fire) begin
        unique case (pdps_pkg::cfg_reg_e'(cfg_index_i))
          pdps_pkg::REG_DUTY_STEP:            cfg_q.duty_step            <= cfg_data_i;
          pdps_pkg::REG_PHASE_STEP:           cfg_q.phase_step           <= cfg_data_i;
          pdps_pkg::REG_PERIOD_COUNT:         cfg_q.period_count         <= cfg_data_i;
          pdps_pkg::REG_DUTY_UPPER_FRACTION:  cfg_q.duty_upper_fraction  <= cfg_data_i;
          pdps_pkg::REG_DUTY_LOWER_FRACTION:  cfg_q.duty_lower_fraction  <= cfg_data_i;
          pdps_pkg::REG_PHASE_UPPER_FRACTION: cfg_q.phase_upper_fraction <= cfg_data_i;
          pdps_pkg::REG_PHASE_LOWER_FRACTION: cfg_q.phase_lower_fraction <= cfg_data_i;
          pdps_pkg::REG_HELD_DUTY:            cfg_q.held_duty            <= cfg_data_i;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: the input register moves on whenever the result register is
  // empty or being emptied and no write settles; then one beat flows per cycle.
  // ---------------------------------------------------------------------------
  assign advance    = s1_valid_q & ~settle_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~s1_valid_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      s1_restart_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q   <= in_valid_i;
      s1_restart_q <= restart_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Bounds
  // ---------------------------------------------------------------------------
  assign phase_mode = (cfg_q.phase_step != '0);
  assign use_held   = s1_valid_q & s1_restart_q & phase_mode;

  pdps_bounds u_bounds (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .duty_i     (duty_q),
    .use_held_i (use_held),
    .bounds_o   (bounds)
  );

  // ---------------------------------------------------------------------------
  // One triangle step. A rising value clamps to the upper bound once the step
  // would reach it; a falling value clamps to the lower bound once it is at or
  // below the bound plus the step. Both sums are one bit wider so they cannot
  // wrap.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (phase_mode) begin
      sw_val  = phase_q;
      sw_step = cfg_q.phase_step;
      sw_lo   = bounds.phase_lo;
      sw_hi   = bounds.phase_hi;
    end else begin
      sw_val  = duty_q;
      sw_step = cfg_q.duty_step;
      sw_lo   = bounds.duty_lo;
      sw_hi   = bounds.duty_hi;
    end
  end

  assign rise_sum   = {1'b0, pdps_pkg::count_to_base(sw_val)} +
                      {1'b0, pdps_pkg::cfg_to_base(sw_step)};
  assign fall_limit = {1'b0, pdps_pkg::count_to_base(sw_lo)} +
                      {1'b0, pdps_pkg::cfg_to_base(sw_step)};
  assign fall_diff  = pdps_pkg::count_to_base(sw_val) - pdps_pkg::cfg_to_base(sw_step);
  assign rise_hit   = rise_sum >= {1'b0, pdps_pkg::count_to_base(sw_hi)};
  assign fall_hit   = {1'b0, pdps_pkg::count_to_base(sw_val)} <= fall_limit;

  always_comb begin
    sw_next   = sw_val;
    falling_d = falling_q;
    if (!falling_q) begin
      if (rise_hit) begin
        sw_next   = sw_hi;
        falling_d = 1'b1;
      end else begin
        sw_next = rise_sum[CW-1:0];
      end
    end else begin
      if (fall_hit) begin
        sw_next   = sw_lo;
        falling_d = 1'b0;
      end else begin
        sw_next = fall_diff[CW-1:0];
      end
    end

    duty_d  = duty_q;
    phase_d = phase_q;
    if (s1_restart_q) begin
      // Restart: the phase sweep starts from the held duty, the duty sweep
      // from its lower bound with no phase offset.
      falling_d = 1'b0;
      if (phase_mode) begin
        duty_d  = pdps_pkg::cfg_to_count(cfg_q.held_duty);
        phase_d = bounds.restart_phase;
      end else begin
        duty_d  = bounds.duty_lo;
        phase_d = '0;
      end
    end else if (phase_mode) begin
      phase_d = sw_next;
    end else begin
      duty_d = sw_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q    <= CW'(pdps_pkg::START_DUTY);
      phase_q   <= '0;
      falling_q <= 1'b0;
    end else if (advance) begin
      duty_q    <= duty_d;
      phase_q   <= phase_d;
      falling_q <= falling_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Compare values from the new state.
  // ---------------------------------------------------------------------------
  assign twice    = {phase_d, 1'b0};
  assign lead_sum = {2'b00, duty_d} + {1'b0, twice};
  assign lag_diff = {1'b0, duty_d} - twice;
  assign lead_val = (lead_sum[CW+1:CW] != 2'b00) ? '1 : lead_sum[CW-1:0];
  assign lag_val  = ({1'b0, duty_d} >= twice) ? lag_diff[CW-1:0] : '0;

  assign center_w = pdps_pkg::count_to_base(duty_d);
  assign lead_w   = pdps_pkg::count_to_base(lead_val);
  assign lag_w    = pdps_pkg::count_to_base(lag_val);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      center_q <= center_w[pdps_pkg::OUT_W-1:0];
      lead_q   <= lead_w[pdps_pkg::OUT_W-1:0];
      lag_q    <= lag_w[pdps_pkg::OUT_W-1:0];
      down_q   <= falling_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign center_compare_o = center_q;
  assign lead_compare_o   = lead_q;
  assign lag_compare_o    = lag_q;
  assign sweeping_down_o  = down_q;

endmodule

@@ test/testbench.sv @@
module testbench;

  // Idling patterns for the tick and result channels.
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  // Scoreboard: keeps its own copy of the register file and of the sweep
  // state, predicts the compare set for every accepted tick, and checks the
  // result beats against those predictions in order.
  class sweep_scoreboard;
    typedef struct {
      logic [pdps_pkg::OUT_W-1:0] center;
      logic [pdps_pkg::OUT_W-1:0] lead;
      logic [pdps_pkg::OUT_W-1:0] lag;
      logic                       down;
    } compare_set_t;

    logic [pdps_pkg::CFG_W-1:0]   regs [8];
    logic [pdps_pkg::COUNT_W-1:0] duty;
    logic [pdps_pkg::COUNT_W-1:0] phase;
    logic                         falling;
    compare_set_t                 compare_q [$];
    int                           errors;

    function new();
      regs[pdps_pkg::REG_DUTY_STEP]            = pdps_pkg::RST_DUTY_STEP;
      regs[pdps_pkg::REG_PHASE_STEP]           = pdps_pkg::RST_PHASE_STEP;
      regs[pdps_pkg::REG_PERIOD_COUNT]         = pdps_pkg::RST_PERIOD_COUNT;
      regs[pdps_pkg::REG_DUTY_UPPER_FRACTION]  = pdps_pkg::RST_DUTY_UPPER;
      regs[pdps_pkg::REG_DUTY_LOWER_FRACTION]  = pdps_pkg::RST_DUTY_LOWER;
      regs[pdps_pkg::REG_PHASE_UPPER_FRACTION] = pdps_pkg::RST_PHASE_UPPER;
      regs[pdps_pkg::REG_PHASE_LOWER_FRACTION] = pdps_pkg::RST_PHASE_LOWER;
      regs[pdps_pkg::REG_HELD_DUTY]            = pdps_pkg::RST_HELD_DUTY;
      duty    = pdps_pkg::COUNT_W'(pdps_pkg::START_DUTY);
      phase   = '0;
      falling = 1'b0;
      errors  = 0;
    endfunction

    function void write_reg(pdps_pkg::cfg_reg_e idx, logic [pdps_pkg::CFG_W-1:0] value);
      regs[idx] = value;
    endfunction

    // Bound = fraction times base, truncated to the integer part.
    function logic [pdps_pkg::COUNT_W-1:0] bound(logic [pdps_pkg::CFG_W-1:0] frac,
                                                 logic [pdps_pkg::COUNT_W-1:0] base);
      logic [31:0] prod;
      prod = frac * base;
      return prod[31:16];
    endfunction

    // One triangle step. Sums are kept one bit wider so they never wrap.
    function logic [pdps_pkg::COUNT_W-1:0] triangle_step(
      logic [pdps_pkg::COUNT_W-1:0] v, logic [pdps_pkg::CFG_W-1:0] s,
      logic [pdps_pkg::COUNT_W-1:0] lo, logic [pdps_pkg::COUNT_W-1:0] hi);
      logic [pdps_pkg::COUNT_W:0] sum;
      if (!falling) begin
        sum = {1'b0, v} + s;
        if (sum >= {1'b0, hi}) begin
          falling = 1'b1;
          return hi;
        end
        return sum[pdps_pkg::COUNT_W-1:0];
      end
      sum = {1'b0, lo} + s;
      if ({1'b0, v} <= sum) begin
        falling = 1'b0;
        return lo;
      end
      return v - s;
    endfunction

    function void note_tick(logic restart);
      logic [pdps_pkg::COUNT_W:0]   twice;
      logic [pdps_pkg::COUNT_W+1:0] lead_sum;
      logic [pdps_pkg::COUNT_W:0]   lag_diff;
      logic [pdps_pkg::COUNT_W-1:0] lo;
      logic [pdps_pkg::COUNT_W-1:0] hi;
      compare_set_t                 e;
      if (restart) begin
        falling = 1'b0;
        if (regs[pdps_pkg::REG_PHASE_STEP] == 0) begin
          duty  = bound(regs[pdps_pkg::REG_DUTY_LOWER_FRACTION],
                        regs[pdps_pkg::REG_PERIOD_COUNT]);
          phase = '0;
        end else begin
          duty  = regs[pdps_pkg::REG_HELD_DUTY];
          phase = bound(regs[pdps_pkg::REG_PHASE_LOWER_FRACTION], duty);
        end
      end else if (regs[pdps_pkg::REG_PHASE_STEP] == 0) begin
        lo   = bound(regs[pdps_pkg::REG_DUTY_LOWER_FRACTION], regs[pdps_pkg::REG_PERIOD_COUNT]);
        hi   = bound(regs[pdps_pkg::REG_DUTY_UPPER_FRACTION], regs[pdps_pkg::REG_PERIOD_COUNT]);
        duty = triangle_step(duty, regs[pdps_pkg::REG_DUTY_STEP], lo, hi);
      end else begin
        lo    = bound(regs[pdps_pkg::REG_PHASE_LOWER_FRACTION], duty);
        hi    = bound(regs[pdps_pkg::REG_PHASE_UPPER_FRACTION], duty);
        phase = triangle_step(phase, regs[pdps_pkg::REG_PHASE_STEP], lo, hi);
      end
      twice    = {phase, 1'b0};
      lead_sum = {2'b00, duty} + {1'b0, twice};
      lag_diff = {1'b0, duty} - twice;
      e.center = duty;
      e.lead   = (lead_sum > 18'h0FFFF) ? 16'hFFFF : lead_sum[15:0];
      e.lag    = ({1'b0, duty} >= twice) ? lag_diff[15:0] : 16'h0000;
      e.down   = falling;
      compare_q.push_back(e);
    endfunction

    function void check_field(string name, logic [pdps_pkg::OUT_W-1:0] exp,
                              logic [pdps_pkg::OUT_W-1:0] act);
      if (act !== exp) begin
        $error("%s: expected %0d, got %0d", name, exp, act);
        errors++;
      end
    endfunction

    function void check_result(logic [pdps_pkg::OUT_W-1:0] center,
                               logic [pdps_pkg::OUT_W-1:0] lead,
                               logic [pdps_pkg::OUT_W-1:0] lag, logic down);
      compare_set_t e;
      if (compare_q.size() == 0) begin
        $error("result beat with no prediction waiting");
        errors++;
        return;
      end
      e = compare_q.pop_front();
      check_field("center_compare", e.center, center);
      check_field("lead_compare", e.lead, lead);
      check_field("lag_compare", e.lag, lag);
      check_field("sweeping_down", pdps_pkg::OUT_W'(e.down), pdps_pkg::OUT_W'(down));
    endfunction

    function int pending();
      return compare_q.size();
    endfunction
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [pdps_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [pdps_pkg::CFG_W-1:0]     cfg_data_i;
  logic                           in_valid_i;
  logic                           in_ready_o;
  logic                           restart_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  logic [pdps_pkg::OUT_W-1:0]     center_compare_o;
  logic [pdps_pkg::OUT_W-1:0]     lead_compare_o;
  logic [pdps_pkg::OUT_W-1:0]     lag_compare_o;
  logic                           sweeping_down_o;

  sweep_scoreboard sb;

  // Register values that the next configuration pass writes, by register index.
  logic [pdps_pkg::CFG_W-1:0] cfg_set [8];

  // Current idling: chance in percent that the sender skips a cycle and that
  // the receiver stalls a cycle.
  int send_idle_pct;
  int recv_stall_pct;
  // Set by the stimulus to ask the receiver for one long hold-off.
  bit hold_req;

  pwm_duty_phase_sweep_unit u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .restart_i        (restart_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .center_compare_o (center_compare_o),
    .lead_compare_o   (lead_compare_o),
    .lag_compare_o    (lag_compare_o),
    .sweeping_down_o  (sweeping_down_o)
  );

  always #4 clk_i = ~clk_i;

  // Every result beat is checked at the rising edge where it is taken.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(center_compare_o, lead_compare_o, lag_compare_o, sweeping_down_o);
    end
  end

  // Result side. Ready changes only at falling edges. A hold-off request
  // keeps ready low for a long stretch so that the unit backs up and has to
  // stall the tick channel.
  initial begin
    int hold_left;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 60;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  function automatic void set_idle(idle_mode_e mode);
    unique case (mode)
      IDLE_NONE: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct  = 64;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct  = 0;
        recv_stall_pct = 64;
      end
      default: begin
        send_idle_pct  = 27;
        recv_stall_pct = 27;
      end
    endcase
  endfunction

  // Register values are drawn from a mix of the extremes, small values and
  // the full range, so that bounds and steps meet in every order.
  function automatic logic [pdps_pkg::CFG_W-1:0] pick_reg_value();
    unique case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      4:       return pdps_pkg::CFG_W'($urandom_range(0, 255));
      5:       return pdps_pkg::CFG_W'($urandom_range(0, 4095));
      default: return pdps_pkg::CFG_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Offers one tick beat. It starts and ends at a falling edge and leaves
  // valid high, so that back-to-back beats need no second assignment in a
  // time step; an idle gap lowers valid first.
  task automatic send_tick(input logic restart);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_tick(restart);
    @(negedge clk_i);
  endtask

  // Stops the tick stream and waits until every predicted result has come
  // back, then idles on so that the pipeline can settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  // Writes all registers from cfg_set, one beat per register.
  task automatic apply_config();
    for (int i = 0; i < 8; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= pdps_pkg::cfg_reg_e'(i);
      cfg_data_i  <= cfg_set[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.write_reg(pdps_pkg::cfg_reg_e'(i), cfg_set[i]);
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int total;
    int n;
    int phase_no;
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = pdps_pkg::REG_DUTY_STEP;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    restart_i      = 1'b0;
    hold_req       = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    sb             = new();
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Registers as they come out of reset: the phase sweeps around the start
    // duty, then a restart reloads the phase from the held duty.
    repeat (3) send_tick(1'b0);
    send_tick(1'b1);
    repeat (2) send_tick(1'b0);
    drain();

    // Every register at full scale: the lead compare saturates, the lag
    // compare bottoms out and the phase clamps on every tick.
    foreach (cfg_set[i]) cfg_set[i] = '1;
    apply_config();
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    drain();

    // Duty sweep over the whole period with a large step, so that it clamps
    // at the top and at the bottom and turns around at both.
    cfg_set[pdps_pkg::REG_DUTY_STEP]           = 16'd30000;
    cfg_set[pdps_pkg::REG_PHASE_STEP]          = '0;
    cfg_set[pdps_pkg::REG_PERIOD_COUNT]        = '1;
    cfg_set[pdps_pkg::REG_DUTY_UPPER_FRACTION] = '1;
    cfg_set[pdps_pkg::REG_DUTY_LOWER_FRACTION] = '0;
    apply_config();
    send_tick(1'b1);
    repeat (6) send_tick(1'b0);
    drain();

    // Phase sweep whose lower bound sits above its upper bound, so that it
    // bounces between the two on every tick.
    cfg_set[pdps_pkg::REG_PHASE_STEP]           = 16'd500;
    cfg_set[pdps_pkg::REG_HELD_DUTY]            = 16'd8000;
    cfg_set[pdps_pkg::REG_PHASE_UPPER_FRACTION] = 16'd4096;
    cfg_set[pdps_pkg::REG_PHASE_LOWER_FRACTION] = 16'd16384;
    apply_config();
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    drain();

    // All registers zero: the mode flips to the duty sweep with the state
    // left as it is, and a restart then loads a zero duty.
    foreach (cfg_set[i]) cfg_set[i] = '0;
    apply_config();
    repeat (2) send_tick(1'b0);
    send_tick(1'b1);
    drain();

    // Random part: phases with fresh register values, about half of them in
    // duty sweep mode, with the idling pattern rotating from phase to phase.
    // Some phases carry on from the previous state without a restart, which
    // exercises mode changes on live state.
    total    = 0;
    phase_no = 0;
    while (total < 400) begin
      foreach (cfg_set[i]) begin
        if ($urandom_range(0, 3) != 0) cfg_set[i] = pick_reg_value();
      end
      cfg_set[pdps_pkg::REG_PHASE_STEP] = $urandom_range(0, 1) ? '0 : pick_reg_value();
      apply_config();
      set_idle(idle_mode_e'(phase_no % 4));
      n = $urandom_range(15, 40);
      for (int k = 0; k < n; k++) begin
        // One phase without idling gets a long receiver hold-off part way in.
        if (phase_no == 4 && k == n / 3) hold_req = 1'b1;
        send_tick((k == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 11) == 0));
      end
      total += n;
      drain();
      phase_no++;
    end

    if (sb.errors == 0) begin
      $display("pwm_duty_phase_sweep_unit: match");
    end else begin
      $display("pwm_duty_phase_sweep_unit: mismatch");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #3000000;
    $display("pwm_duty_phase_sweep_unit: mismatch");
    $finish;
  end

endmodule
